// ----- sv/blap_pkg.sv -----
// shared types, constants and bit-level helpers for the BLE advertising packet receiver
// no dependencies; imported by every module of the block

package blap_pkg;

   // configuration register indexes
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACCESS_ADDRESS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL        = 1'd1;

   // register reset values
   localparam logic [31:0] ACCESS_ADDRESS_RESET = 32'h8E89_BED6;
   localparam logic [5:0]  CHANNEL_RESET        = 6'd37;

   // crc and whitening constants
   localparam logic [23:0] CRC_SEED  = 24'hAA_AAAA;
   localparam logic [23:0] CRC_POLY  = 24'h5A_6000;
   localparam logic [7:0]  WHITE_TAP = 8'h11;
   localparam logic [7:0]  WHITE_SET = 8'h02;

   // header checks
   localparam logic [3:0] PDU_TYPE_MAX = 4'd6;
   localparam logic [5:0] PDU_LEN_MIN  = 6'd1;
   localparam logic [6:0] CRC_BYTES    = 7'd3;

   // result kinds
   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_CRC     = 2'd2;

   typedef enum logic [1:0] {
      PH_SEARCH = 2'd0,
      PH_HEADER = 2'd1,
      PH_DATA   = 2'd2
   } phase_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] value;
      logic        last;
      logic        crc_ok;
   } rsp_type;

   // whitening seed: bit-reversed 6-bit channel in an 8-bit field, bit 1 set
   function automatic logic [7:0] white_seed(input logic [5:0] ch);
      white_seed = {ch[0], ch[1], ch[2], ch[3], ch[4], ch[5], 1'b0, 1'b0} | WHITE_SET;
   endfunction

   // advance the whitening lfsr by one bit
   function automatic logic [7:0] white_step(input logic [7:0] lfsr);
      logic [7:0] t;
      t = lfsr[7] ? (lfsr ^ WHITE_TAP) : lfsr;
      white_step = {t[6:0], 1'b0};
   endfunction

   // advance the crc register by one data bit
   function automatic logic [23:0] crc_step(input logic [23:0] crc, input logic d);
      logic [23:0] t;
      t = {1'b0, crc[23:1]};
      if (crc[0] ^ d) begin
         t = {1'b1, t[22:0]} ^ CRC_POLY;
      end
      crc_step = t;
   endfunction

endpackage

// ----- sv/blap_req_if.sv -----
// request channel: one demodulated bit per transaction
// no dependencies

interface blap_req_if;
   logic valid;
   logic ready;
   logic in_bit;

   modport source (output valid, output in_bit, input ready);
   modport sink   (input valid, input in_bit, output ready);
endinterface

// ----- sv/blap_rsp_if.sv -----
// response channel: header word, payload byte or crc byte per transaction
// no dependencies

interface blap_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [15:0] value;
   logic        last;
   logic        crc_ok;

   modport source (output valid, output kind, output value, output last, output crc_ok,
                   input ready);
   modport sink   (input valid, input kind, input value, input last, input crc_ok,
                   output ready);
endinterface

// ----- sv/ble_adv_packet_receiver.sv -----
// top level of the BLE advertising packet receiver: config registers and submodule wiring
// depends on blap_pkg, blap_req_if, blap_rsp_if, blap_correlator, blap_deframer,
// blap_rsp_stage

// Takes one demodulated bit per request transaction, in air order, and takes a new bit
// in every cycle: the correlator and the deframer state machine handle each bit as it is
// accepted, and a result enters the output register at the edge that accepts the
// bit that completes it, so it is offered from the next cycle on. Request ready drops
// only while a result sits in the output register and the response side is not ready. A
// packet starts when the last 32 bits, first bit as lsb, equal access_address; it yields
// a header word, one response per payload byte, and three crc bytes, the last flagged
// with last and crc_ok. Headers with length 0 or 1 or PDU type above 6 are dropped
// silently. Change access_address and channel only while idle.

module ble_adv_packet_receiver
   import blap_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   blap_req_if.sink               req_bus,
   blap_rsp_if.source             rsp_bus
);

   logic [31:0] access_address_ff;
   logic [5:0]  channel_ff;
   logic        step;
   logic        free;
   logic        match;
   logic        emit;
   rsp_type     result;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         access_address_ff <= ACCESS_ADDRESS_RESET;
         channel_ff        <= CHANNEL_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ACCESS_ADDRESS: access_address_ff <= csr_wdata[31:0];
            CSR_CHANNEL:        channel_ff        <= csr_wdata[5:0];
            default:            ;
         endcase
      end
   end

   // request handshake
   assign req_bus.ready = free;
   assign step          = req_bus.valid && free;

   blap_correlator u_correlator (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .in_bit         (req_bus.in_bit),
      .access_address (access_address_ff),
      .match          (match)
   );

   blap_deframer u_deframer (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .in_bit  (req_bus.in_bit),
      .match   (match),
      .channel (channel_ff),
      .emit    (emit),
      .result  (result)
   );

   blap_rsp_stage u_rsp_stage (
      .clock   (clock),
      .reset   (reset),
      .load    (step),
      .emit    (emit),
      .result  (result),
      .free    (free),
      .rsp_bus (rsp_bus)
   );

endmodule

// ----- sv/blap_correlator.sv -----
// bit window and access address correlator
// depends on blap_pkg

module blap_correlator
   import blap_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic        in_bit,
   input  logic [31:0] access_address,
   output logic        match
);

   logic [31:0] window_ff;
   logic [31:0] window_in;
   logic [31:0] addr_rev;

   // first received bit is the address lsb, so compare against the reversed address
   always_comb begin
      for (int i = 0; i < 32; i++) begin
         addr_rev[i] = access_address[31-i];
      end
   end

   assign window_in = {window_ff[30:0], in_bit};
   assign match     = (window_in == addr_rev);

   // window shifts on every accepted bit
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (step) begin
         window_ff <= window_in;
      end
   end

endmodule

// ----- sv/blap_deframer.sv -----
// packet state machine: dewhitening, crc, header check and byte assembly
// depends on blap_pkg

module blap_deframer
   import blap_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic       in_bit,
   input  logic       match,
   input  logic [5:0] channel,
   output logic       emit,
   output rsp_type    result
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  whiten_ff, whiten_in;
   logic [4:0]  bit_count_ff, bit_count_in;
   logic [6:0]  byte_count_ff, byte_count_in;
   logic [5:0]  pdu_length_ff, pdu_length_in;
   logic [23:0] crc_ff, crc_in;
   logic [23:0] asm_ff, asm_in;

   logic        d;
   logic [23:0] asm_next;
   logic [23:0] crc_next;
   logic [4:0]  bit_inc;
   logic [6:0]  byte_inc;
   logic [15:0] hdr;
   logic [5:0]  hdr_len;
   logic [3:0]  hdr_type;

   // per-bit datapath shared by header and data phases
   assign d        = in_bit ^ whiten_ff[7];
   assign asm_next = {d, asm_ff[23:1]};
   assign crc_next = crc_step(crc_ff, d);
   assign bit_inc  = bit_count_ff + 5'd1;
   assign byte_inc = byte_count_ff + 7'd1;
   assign hdr      = {asm_next[15:8], asm_next[23:16]};
   assign hdr_len  = hdr[5:0];
   assign hdr_type = hdr[11:8];

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SEARCH;
         whiten_ff     <= white_seed(CHANNEL_RESET);
         bit_count_ff  <= '0;
         byte_count_ff <= '0;
         pdu_length_ff <= '0;
         crc_ff        <= CRC_SEED;
         asm_ff        <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         whiten_ff     <= whiten_in;
         bit_count_ff  <= bit_count_in;
         byte_count_ff <= byte_count_in;
         pdu_length_ff <= pdu_length_in;
         crc_ff        <= crc_in;
         asm_ff        <= asm_in;
      end
   end

   // next state and result
   always_comb begin
      phase_in      = phase_ff;
      whiten_in     = whiten_ff;
      bit_count_in  = bit_count_ff;
      byte_count_in = byte_count_ff;
      pdu_length_in = pdu_length_ff;
      crc_in        = crc_ff;
      asm_in        = asm_ff;
      emit          = 1'b0;
      result        = '{kind: KIND_HEADER, value: hdr, last: 1'b0, crc_ok: 1'b0};

      unique case (phase_ff)
         PH_HEADER: begin
            whiten_in    = white_step(whiten_ff);
            asm_in       = asm_next;
            crc_in       = crc_next;
            bit_count_in = bit_inc;
            if (bit_inc == 5'd16) begin
               if (hdr_len <= PDU_LEN_MIN || hdr_type > PDU_TYPE_MAX) begin
                  phase_in = PH_SEARCH;
               end else begin
                  pdu_length_in = hdr_len;
                  bit_count_in  = '0;
                  byte_count_in = '0;
                  phase_in      = PH_DATA;
                  emit          = 1'b1;
               end
            end
         end
         PH_DATA: begin
            whiten_in    = white_step(whiten_ff);
            asm_in       = asm_next;
            bit_count_in = bit_inc;
            // in this phase the crc takes payload bytes only, not the received crc bytes
            if (byte_count_ff < {1'b0, pdu_length_ff}) begin
               crc_in = crc_next;
            end
            if (bit_inc[3]) begin
               bit_count_in  = '0;
               byte_count_in = byte_inc;
               emit          = 1'b1;
               result.value  = {8'd0, asm_next[23:16]};
               if (byte_inc <= {1'b0, pdu_length_ff}) begin
                  result.kind = KIND_PAYLOAD;
               end else begin
                  result.kind = KIND_CRC;
                  if (byte_inc >= ({1'b0, pdu_length_ff} + CRC_BYTES)) begin
                     result.last   = 1'b1;
                     result.crc_ok = (asm_next == crc_in);
                     phase_in      = PH_SEARCH;
                  end
               end
            end
         end
         default: begin
            // search, also the unused phase code
            phase_in = PH_SEARCH;
            if (match) begin
               whiten_in     = white_seed(channel);
               crc_in        = CRC_SEED;
               bit_count_in  = '0;
               byte_count_in = '0;
               asm_in        = '0;
               phase_in      = PH_HEADER;
            end
         end
      endcase
   end

endmodule

// ----- sv/blap_rsp_stage.sv -----
// output register that holds one result until the sink takes it
// depends on blap_pkg and blap_rsp_if

module blap_rsp_stage
   import blap_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  logic    emit,
   input  rsp_type result,
   output logic    free,
   blap_rsp_if.source rsp_bus
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   // a new transaction may enter when the register is empty or drains this cycle
   assign free = !valid_ff || rsp_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = emit;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (load && emit) begin
         data_ff <= result;
      end
   end

   assign rsp_bus.valid  = valid_ff;
   assign rsp_bus.kind   = data_ff.kind;
   assign rsp_bus.value  = data_ff.value;
   assign rsp_bus.last   = data_ff.last;
   assign rsp_bus.crc_ok = data_ff.crc_ok;

endmodule

// ----- tb/sv/blap_tb_pkg.sv -----
`timescale 1ns / 1ps
// bit-level whitening and crc helpers plus the expected-result tracker for the receiver bench
// depends on blap_pkg

package blap_tb_pkg;
   import blap_pkg::*;

   // whitening seed: channel bits mirrored into the top six bits, bit 1 always set
   function automatic logic [7:0] whiten_seed(input logic [5:0] ch);
      logic [7:0] s;
      s = WHITE_SET;
      for (int i = 0; i < 6; i++) s[7 - i] = ch[i];
      return s;
   endfunction

   // one whitening shift; the top bit is the mask bit used before the shift
   function automatic logic [7:0] whiten_next(input logic [7:0] s);
      if (s[7]) s = s ^ WHITE_TAP;
      return {s[6:0], 1'b0};
   endfunction

   // one crc shift, feedback taken from bit 0
   function automatic logic [23:0] crc_next(input logic [23:0] c, input logic d);
      logic fb;
      fb = c[0] ^ d;
      c = c >> 1;
      if (fb) c = c ^ 24'h80_0000 ^ CRC_POLY;
      return c;
   endfunction

   class adv_rx_predictor;
      logic [31:0] addr;
      logic [5:0]  chan;
      phase_type   phase;
      logic [31:0] window;
      logic [7:0]  white;
      logic [4:0]  nbits;
      logic [6:0]  nbytes;
      logic [5:0]  pdu_len;
      logic [23:0] crc;
      logic [23:0] shift24;
      rsp_type     due_results[$];
      int          failures;

      function new();
         addr     = ACCESS_ADDRESS_RESET;
         chan     = CHANNEL_RESET;
         phase    = PH_SEARCH;
         window   = '0;
         white    = whiten_seed(CHANNEL_RESET);
         nbits    = '0;
         nbytes   = '0;
         pdu_len  = '0;
         crc      = CRC_SEED;
         shift24  = '0;
         failures = 0;
      endfunction

      function void set_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_ACCESS_ADDRESS) addr = data;
         else if (idx == CSR_CHANNEL) chan = data[5:0];
      endfunction

      // dewhiten one bit and shift it into the top of the 24-bit assembly register
      function logic dewhiten(input logic b);
         logic d;
         d = b ^ white[7];
         white = whiten_next(white);
         shift24 = {d, shift24[23:1]};
         return d;
      endfunction

      // one accepted bit transaction; queues the result it completes, if any
      function void take_bit(input logic b);
         logic        d;
         logic [31:0] rev;
         logic [15:0] hdr;
         rsp_type     r;
         window = {window[30:0], b};
         case (phase)
            PH_HEADER: begin
               d = dewhiten(b);
               crc = crc_next(crc, d);
               nbits = nbits + 5'd1;
               if (nbits == 5'd16) begin
                  hdr = {shift24[15:8], shift24[23:16]};
                  // short length or reserved pdu type drops the packet silently
                  if (hdr[5:0] <= PDU_LEN_MIN || hdr[11:8] > PDU_TYPE_MAX) begin
                     phase = PH_SEARCH;
                  end else begin
                     pdu_len = hdr[5:0];
                     nbits   = '0;
                     nbytes  = '0;
                     phase   = PH_DATA;
                     r = '{kind: KIND_HEADER, value: hdr, last: 1'b0, crc_ok: 1'b0};
                     due_results.push_back(r);
                  end
               end
            end
            PH_DATA: begin
               d = dewhiten(b);
               // in this phase the crc takes payload bytes only, not the received crc
               if (nbytes < {1'b0, pdu_len}) crc = crc_next(crc, d);
               nbits = nbits + 5'd1;
               if (nbits >= 5'd8) begin
                  nbits  = '0;
                  nbytes = nbytes + 7'd1;
                  r = '{kind: KIND_PAYLOAD, value: {8'h00, shift24[23:16]},
                        last: 1'b0, crc_ok: 1'b0};
                  if (nbytes > {1'b0, pdu_len}) begin
                     r.kind = KIND_CRC;
                     if (nbytes >= {1'b0, pdu_len} + CRC_BYTES) begin
                        r.last   = 1'b1;
                        r.crc_ok = (shift24 == crc);
                        phase    = PH_SEARCH;
                     end
                  end
                  due_results.push_back(r);
               end
            end
            default: begin
               // search: window read with the first bit as lsb
               phase = PH_SEARCH;
               for (int i = 0; i < 32; i++) rev[i] = window[31 - i];
               if (rev == addr) begin
                  white   = whiten_seed(chan);
                  crc     = CRC_SEED;
                  nbits   = '0;
                  nbytes  = '0;
                  shift24 = '0;
                  phase   = PH_HEADER;
               end
            end
         endcase
      endfunction

      function void note_failure(input string msg);
         failures++;
         if (failures <= 10) $display("%0t: %s", $realtime, msg);
      endfunction

      // one accepted result transaction against the oldest expectation
      function void check_result(input rsp_type got);
         rsp_type want;
         if (due_results.size() == 0) begin
            note_failure($sformatf("unexpected result kind=%0d value=%h last=%b crc_ok=%b",
                                   got.kind, got.value, got.last, got.crc_ok));
            return;
         end
         want = due_results.pop_front();
         if (got.kind !== want.kind || got.value !== want.value ||
             got.last !== want.last || got.crc_ok !== want.crc_ok) begin
            note_failure($sformatf({"result mismatch: expected kind=%0d value=%h last=%b ",
                                    "crc_ok=%b, got kind=%0d value=%h last=%b crc_ok=%b"},
                                   want.kind, want.value, want.last, want.crc_ok,
                                   got.kind, got.value, got.last, got.crc_ok));
         end
      endfunction
   endclass

endpackage

// ----- tb/sv/ble_adv_packet_receiver_tb.sv -----
`timescale 1ns / 1ps
// top-level bench for the packet receiver: drives air bits framed as packets plus noise
// depends on blap_pkg, blap_req_if, blap_rsp_if, blap_tb_pkg and ble_adv_packet_receiver

module ble_adv_packet_receiver_tb;
   import blap_pkg::*;
   import blap_tb_pkg::*;

   localparam int RESET_CYCLES = 8;
   localparam int LONG_HOLD    = 300;
   localparam int CYCLE_LIMIT  = 400000;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   blap_req_if req_if();
   blap_rsp_if rsp_if();

   adv_rx_predictor rx_pred;
   logic [31:0]     cur_aa;
   logic [5:0]      cur_ch;
   int              bits_sent;
   bit              idle_on;
   bit              quiet;
   bit              hold_req;

   ble_adv_packet_receiver dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_bus   (req_if),
      .rsp_bus   (rsp_if)
   );

   always #6 clock = ~clock;

   // cycle limit
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb: failure");
      $finish;
   end

   // response ready: random stall bursts, plus one long hold on request
   initial begin
      int unsigned stall_left;
      bit          hold_done;
      stall_left = 0;
      hold_done  = 1'b0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req && !hold_done) begin
            hold_done  = 1'b1;
            stall_left = LONG_HOLD;
         end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 8);
         end
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // sampled at the falling edge: a transaction completes at the next rising edge
   always @(negedge clock) begin
      if (reset === 1'b0 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         rx_pred.check_result({rsp_if.kind, rsp_if.value, rsp_if.last, rsp_if.crc_ok});
      end
   end

   // one bit transaction, with an occasional gap in front of it
   task automatic send_bit(input logic b);
      if (idle_on && !quiet && $urandom_range(0, 7) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.in_bit <= b;
      do @(negedge clock); while (req_if.ready !== 1'b1);
      @(posedge clock);
      rx_pred.take_bit(b);
      bits_sent++;
   endtask

   task automatic send_noise(input int n);
      for (int i = 0; i < n; i++) send_bit(1'($urandom()));
   endtask

   // preamble, access address, then the whitened header, payload and crc
   task automatic send_packet(input logic [7:0] hdr0, input logic [7:0] hdr1,
                              input bit bad_crc, input bit bad_addr, input int cut_at);
      logic [7:0]  frame[$];
      logic        air_bits[$];
      logic [31:0] addr;
      logic [23:0] crc;
      logic [7:0]  white;
      addr = cur_aa;
      if (bad_addr) addr = addr ^ (32'd1 << $urandom_range(0, 31));
      // alternating preamble ending opposite to the first address bit
      for (int i = 0; i < 8; i++) send_bit(cur_aa[0] ^ i[0]);
      for (int i = 0; i < 32; i++) send_bit(addr[i]);
      frame.push_back(hdr0);
      frame.push_back(hdr1);
      if (hdr1[5:0] > PDU_LEN_MIN && hdr0[3:0] <= PDU_TYPE_MAX) begin
         for (int i = 0; i < int'(hdr1[5:0]); i++) frame.push_back(8'($urandom()));
      end
      crc = CRC_SEED;
      foreach (frame[k]) begin
         for (int i = 0; i < 8; i++) begin
            air_bits.push_back(frame[k][i]);
            crc = crc_next(crc, frame[k][i]);
         end
      end
      // a dropped header gets no crc; whatever follows is search traffic
      if (frame.size() > 2) begin
         if (bad_crc) crc = crc ^ (24'd1 << $urandom_range(0, 23));
         for (int i = 0; i < 24; i++) air_bits.push_back(crc[i]);
      end
      white = whiten_seed(cur_ch);
      foreach (air_bits[k]) begin
         if (cut_at >= 0 && k >= cut_at) break;
         send_bit(air_bits[k] ^ white[7]);
         white = whiten_next(white);
      end
   endtask

   // mostly well-formed packets with random content, some noise and broken ones
   task automatic random_packet();
      logic [7:0] hdr0;
      logic [7:0] hdr1;
      int         pick;
      hdr0 = 8'($urandom());
      pick = $urandom_range(0, 99);
      hdr0[3:0] = (pick < 88) ? 4'($urandom_range(0, 6)) : 4'($urandom_range(7, 15));
      hdr1 = 8'($urandom());
      pick = $urandom_range(0, 99);
      if (pick < 6) hdr1[5:0] = 6'($urandom_range(0, 1));
      else if (pick < 8) hdr1[5:0] = 6'd63;
      else if (pick < 25) hdr1[5:0] = 6'($urandom_range(9, 24));
      else hdr1[5:0] = 6'($urandom_range(2, 8));
      quiet = ($urandom_range(0, 3) == 0);
      send_noise($urandom_range(0, 10));
      pick = $urandom_range(0, 99);
      send_packet(hdr0, hdr1, $urandom_range(0, 6) == 0, pick < 6,
                  (pick >= 6 && pick < 12) ? int'($urandom_range(16, 120)) : -1);
   endtask

   task automatic run_random(input int budget);
      int start;
      start = bits_sent;
      while (bits_sent - start < budget) random_packet();
   endtask

   // stop offering and wait for every queued result, then a few cycles more
   task automatic drain();
      req_if.valid <= 1'b0;
      while (rx_pred.due_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // both registers, written back to back while idle
   task automatic apply_settings(input logic [31:0] aa, input logic [5:0] ch);
      logic [31:0] ch_word;
      ch_word = $urandom();
      ch_word[5:0] = ch;
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_ACCESS_ADDRESS;
      csr_wdata <= aa;
      @(posedge clock);
      csr_index <= CSR_CHANNEL;
      csr_wdata <= ch_word;
      @(posedge clock);
      csr_we <= 1'b0;
      rx_pred.set_register(CSR_ACCESS_ADDRESS, aa);
      rx_pred.set_register(CSR_CHANNEL, ch_word);
      cur_aa = aa;
      cur_ch = ch;
   endtask

   initial begin
      rx_pred   = new();
      cur_aa    = ACCESS_ADDRESS_RESET;
      cur_ch    = CHANNEL_RESET;
      bits_sent = 0;
      idle_on   = 1'b1;
      quiet     = 1'b0;
      hold_req  = 1'b0;
      reset         <= 1'b1;
      csr_we        <= 1'b0;
      csr_index     <= CSR_ACCESS_ADDRESS;
      csr_wdata     <= '0;
      req_if.valid  <= 1'b0;
      req_if.in_bit <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed packets at the reset settings; the sink holds off during the first
      hold_req = 1'b1;
      send_packet(8'h00, 8'h02, 1'b0, 1'b0, -1);   // shortest good packet, type 0
      send_noise(3);
      send_packet(8'hF6, 8'hC3, 1'b1, 1'b0, -1);   // type 6, high length bits set, bad crc
      send_noise(2);
      send_packet(8'h02, 8'h01, 1'b0, 1'b0, -1);   // length 1 dropped
      send_packet(8'h07, 8'h05, 1'b0, 1'b0, -1);   // type 7 dropped
      send_packet(8'h03, 8'h02, 1'b0, 1'b1, 16);   // corrupted address, no match
      send_packet(8'h04, 8'h06, 1'b0, 1'b0, 30);   // cut short mid payload
      drain();

      // random traffic over several register settings
      apply_settings(32'h0000_0000, 6'd0);
      run_random(60);
      drain();
      apply_settings($urandom(), 6'd63);
      run_random(60);
      drain();
      // closing stretch without gaps or stalls
      idle_on = 1'b0;
      apply_settings(ACCESS_ADDRESS_RESET, 6'($urandom_range(0, 39)));
      run_random(60);
      drain();
      repeat (8) @(posedge clock);

      if (rx_pred.failures == 0 && rx_pred.due_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/blap_pkg.sv
sv/blap_req_if.sv
sv/blap_rsp_if.sv
sv/blap_correlator.sv
sv/blap_deframer.sv
sv/blap_rsp_stage.sv
sv/ble_adv_packet_receiver.sv
tb/sv/blap_tb_pkg.sv
tb/sv/ble_adv_packet_receiver_tb.sv
